FILE: sv/ofs_pkg.sv
// Shared types, constants and the update microprogram for the orientation filter.
// Used by every module of the block but ofs_regfile; no dependencies.
package ofs_pkg;

  // Q16.16 constants
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Configuration reset values
  localparam logic [30:0] BETA_RST    = 31'd6554;
  localparam logic [30:0] GATE_LO_RST = 31'd53084;
  localparam logic [30:0] GATE_HI_RST = 31'd79299;

  typedef enum logic [1:0] {
    CFG_BETA    = 2'd0,
    CFG_GATE_LO = 2'd1,
    CFG_GATE_HI = 2'd2
  } cfg_idx_t;

  // Operations of the shared arithmetic unit
  typedef enum logic [3:0] {
    OP_MUL,     // saturating Q16.16 multiply
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_HALF,    // floor shift right by one
    OP_ISQ,     // inverse square root (multi-cycle unit)
    OP_GATE,    // latch accel gate flag from operand a
    OP_GSEL,    // a if gate passed, else zero
    OP_ZIFZ,    // zero if b is zero, else a
    OP_ONEIFZ,  // one if b is zero, else a
    OP_NEGIFN,  // negate a if b is negative
    OP_STO,     // store a to orientation component d
    OP_END
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_FETCH,
    SQ_EXEC,
    SQ_ISQ,
    SQ_DONE
  } seq_state_t;

  // Inverse root unit states
  typedef enum logic [1:0] {
    ISQ_IDLE,
    ISQ_DIV,
    ISQ_ROOT,
    ISQ_DONE
  } isq_state_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] x;
  } isq_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] result;
  } isq_rsp_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] d;
    logic [5:0] a;
    logic [5:0] b;
  } instr_t;

  // Scratch registers (R4 and R5 are running temporaries)
  localparam logic [5:0] R0  = 6'd0,  R1  = 6'd1,  R2  = 6'd2,  R3  = 6'd3;
  localparam logic [5:0] R4  = 6'd4,  R5  = 6'd5,  R6  = 6'd6,  R7  = 6'd7;
  localparam logic [5:0] R8  = 6'd8,  R9  = 6'd9,  R10 = 6'd10, R11 = 6'd11;
  localparam logic [5:0] R12 = 6'd12, R13 = 6'd13, R14 = 6'd14, R15 = 6'd15;
  localparam logic [5:0] R16 = 6'd16, R17 = 6'd17, R18 = 6'd18, R19 = 6'd19;
  localparam logic [5:0] R20 = 6'd20, R21 = 6'd21, R22 = 6'd22, R23 = 6'd23;
  localparam logic [5:0] R24 = 6'd24, R25 = 6'd25, R26 = 6'd26, R27 = 6'd27;
  localparam logic [5:0] R28 = 6'd28, R29 = 6'd29, R30 = 6'd30;

  // Special operands (bit 5 set): item fields, registers, constants, orientation
  localparam logic [5:0] S_RX   = 6'd32, S_RY   = 6'd33, S_RZ = 6'd34;
  localparam logic [5:0] S_AX   = 6'd35, S_AY   = 6'd36, S_AZ = 6'd37;
  localparam logic [5:0] S_DT   = 6'd38, S_BETA = 6'd39;
  localparam logic [5:0] S_ONE  = 6'd40, S_ZERO = 6'd41;
  localparam logic [5:0] S_PW   = 6'd42, S_PX   = 6'd43, S_PY = 6'd44, S_PZ = 6'd45;

  // Orientation slots for OP_STO
  localparam logic [5:0] O_W = 6'd0, O_X = 6'd1, O_Y = 6'd2, O_Z = 6'd3;

  localparam int PROG_DEPTH = 256;

  function automatic instr_t mk(input op_t op, input logic [5:0] d,
                                input logic [5:0] a, input logic [5:0] b);
    instr_t i;
    i.op = op;
    i.d  = d;
    i.a  = a;
    i.b  = b;
    return i;
  endfunction

  // Update program, one instruction per entry
  function automatic instr_t prog_at(input logic [7:0] pc);
    instr_t p [PROG_DEPTH];
    int     n;
    for (int i = 0; i < PROG_DEPTH; i++) p[i] = mk(OP_END, R0, S_ZERO, S_ZERO);
    n = 0;
    // half of previous orientation
    p[n] = mk(OP_HALF, R0, S_PW, S_ZERO); n++;
    p[n] = mk(OP_HALF, R1, S_PX, S_ZERO); n++;
    p[n] = mk(OP_HALF, R2, S_PY, S_ZERO); n++;
    p[n] = mk(OP_HALF, R3, S_PZ, S_ZERO); n++;
    // rate derivative: half x <0, rate> into R6..R9
    p[n] = mk(OP_MUL, R4, R0, S_ZERO); n++;
    p[n] = mk(OP_MUL, R5, R1, S_RX);   n++;
    p[n] = mk(OP_SUB, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R2, S_RY);   n++;
    p[n] = mk(OP_SUB, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R3, S_RZ);   n++;
    p[n] = mk(OP_SUB, R6, R4, R5);     n++;
    p[n] = mk(OP_MUL, R4, R0, S_RX);   n++;
    p[n] = mk(OP_MUL, R5, R1, S_ZERO); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R2, S_RZ);   n++;
    p[n] = mk(OP_ADD, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R3, S_RY);   n++;
    p[n] = mk(OP_SUB, R7, R4, R5);     n++;
    p[n] = mk(OP_MUL, R4, R0, S_RY);   n++;
    p[n] = mk(OP_MUL, R5, R1, S_RZ);   n++;
    p[n] = mk(OP_SUB, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R2, S_ZERO); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R3, S_RX);   n++;
    p[n] = mk(OP_ADD, R8, R4, R5);     n++;
    p[n] = mk(OP_MUL, R4, R0, S_RZ);   n++;
    p[n] = mk(OP_MUL, R5, R1, S_RY);   n++;
    p[n] = mk(OP_ADD, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R2, S_RX);   n++;
    p[n] = mk(OP_SUB, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, R3, S_ZERO); n++;
    p[n] = mk(OP_ADD, R9, R4, R5);     n++;
    // squared accel norm, gate, inverse norm
    p[n] = mk(OP_MUL, R4, S_AX, S_AX); n++;
    p[n] = mk(OP_MUL, R5, S_AY, S_AY); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);     n++;
    p[n] = mk(OP_MUL, R5, S_AZ, S_AZ); n++;
    p[n] = mk(OP_ADD, R10, R4, R5);    n++;
    p[n] = mk(OP_GATE, R0, R10, S_ZERO); n++;
    p[n] = mk(OP_ISQ, R11, R10, S_ZERO); n++;
    // negated normalized accel
    p[n] = mk(OP_MUL, R12, R11, S_AX); n++;
    p[n] = mk(OP_NEG, R12, R12, S_ZERO); n++;
    p[n] = mk(OP_MUL, R13, R11, S_AY); n++;
    p[n] = mk(OP_NEG, R13, R13, S_ZERO); n++;
    p[n] = mk(OP_MUL, R14, R11, S_AZ); n++;
    p[n] = mk(OP_NEG, R14, R14, S_ZERO); n++;
    // conjugate vector part
    p[n] = mk(OP_NEG, R16, S_PX, S_ZERO); n++;
    p[n] = mk(OP_NEG, R17, S_PY, S_ZERO); n++;
    p[n] = mk(OP_NEG, R18, S_PZ, S_ZERO); n++;
    // conj x gravity into R19..R22
    p[n] = mk(OP_MUL, R4, S_PW, S_ZERO); n++;
    p[n] = mk(OP_MUL, R5, R16, S_ZERO);  n++;
    p[n] = mk(OP_SUB, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R17, S_ZERO);  n++;
    p[n] = mk(OP_SUB, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R18, S_ONE);   n++;
    p[n] = mk(OP_SUB, R19, R4, R5);      n++;
    p[n] = mk(OP_MUL, R4, S_PW, S_ZERO); n++;
    p[n] = mk(OP_MUL, R5, R16, S_ZERO);  n++;
    p[n] = mk(OP_ADD, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R17, S_ONE);   n++;
    p[n] = mk(OP_ADD, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R18, S_ZERO);  n++;
    p[n] = mk(OP_SUB, R20, R4, R5);      n++;
    p[n] = mk(OP_MUL, R4, S_PW, S_ZERO); n++;
    p[n] = mk(OP_MUL, R5, R16, S_ONE);   n++;
    p[n] = mk(OP_SUB, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R17, S_ZERO);  n++;
    p[n] = mk(OP_ADD, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R18, S_ZERO);  n++;
    p[n] = mk(OP_ADD, R21, R4, R5);      n++;
    p[n] = mk(OP_MUL, R4, S_PW, S_ONE);  n++;
    p[n] = mk(OP_MUL, R5, R16, S_ZERO);  n++;
    p[n] = mk(OP_ADD, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R17, S_ZERO);  n++;
    p[n] = mk(OP_SUB, R4, R4, R5);       n++;
    p[n] = mk(OP_MUL, R5, R18, S_ZERO);  n++;
    p[n] = mk(OP_ADD, R22, R4, R5);      n++;
    // (...) x q, vector part only, into R24..R26
    p[n] = mk(OP_MUL, R4, R19, S_PX); n++;
    p[n] = mk(OP_MUL, R5, R20, S_PW); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R21, S_PZ); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R22, S_PY); n++;
    p[n] = mk(OP_SUB, R24, R4, R5);   n++;
    p[n] = mk(OP_MUL, R4, R19, S_PY); n++;
    p[n] = mk(OP_MUL, R5, R20, S_PZ); n++;
    p[n] = mk(OP_SUB, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R21, S_PW); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R22, S_PX); n++;
    p[n] = mk(OP_ADD, R25, R4, R5);   n++;
    p[n] = mk(OP_MUL, R4, R19, S_PZ); n++;
    p[n] = mk(OP_MUL, R5, R20, S_PY); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R21, S_PX); n++;
    p[n] = mk(OP_SUB, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R22, S_PW); n++;
    p[n] = mk(OP_ADD, R26, R4, R5);   n++;
    // objective f into R27..R29
    p[n] = mk(OP_SUB, R27, R24, R12); n++;
    p[n] = mk(OP_SUB, R28, R25, R13); n++;
    p[n] = mk(OP_SUB, R29, R26, R14); n++;
    // gradient: gw R15, gx R16, gy R17, gz R18
    p[n] = mk(OP_MUL, R4, S_PX, R28); n++;
    p[n] = mk(OP_MUL, R5, S_PY, R27); n++;
    p[n] = mk(OP_SUB, R4, R4, R5);    n++;
    p[n] = mk(OP_ADD, R15, R4, R4);   n++;
    p[n] = mk(OP_MUL, R4, S_PZ, R27); n++;
    p[n] = mk(OP_MUL, R5, S_PW, R28); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, S_PX, R29); n++;
    p[n] = mk(OP_ADD, R5, R5, R5);    n++;
    p[n] = mk(OP_SUB, R4, R4, R5);    n++;
    p[n] = mk(OP_ADD, R16, R4, R4);   n++;
    p[n] = mk(OP_MUL, R4, S_PZ, R28); n++;
    p[n] = mk(OP_MUL, R5, S_PW, R27); n++;
    p[n] = mk(OP_MUL, R0, S_PY, R29); n++;
    p[n] = mk(OP_ADD, R0, R0, R0);    n++;
    p[n] = mk(OP_ADD, R5, R5, R0);    n++;
    p[n] = mk(OP_SUB, R4, R4, R5);    n++;
    p[n] = mk(OP_ADD, R17, R4, R4);   n++;
    p[n] = mk(OP_MUL, R4, S_PX, R27); n++;
    p[n] = mk(OP_MUL, R5, S_PY, R28); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_ADD, R18, R4, R4);   n++;
    // squared gradient norm into R19
    p[n] = mk(OP_MUL, R4, R15, R15); n++;
    p[n] = mk(OP_MUL, R5, R16, R16); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);   n++;
    p[n] = mk(OP_MUL, R5, R17, R17); n++;
    p[n] = mk(OP_MUL, R0, R18, R18); n++;
    p[n] = mk(OP_ADD, R5, R5, R0);   n++;
    p[n] = mk(OP_ADD, R19, R4, R5);  n++;
    // scale = beta / |grad|
    p[n] = mk(OP_ISQ, R20, R19, S_ZERO); n++;
    p[n] = mk(OP_MUL, R20, S_BETA, R20); n++;
    // correction into R21..R24, zero when gradient is zero or gate rejects
    p[n] = mk(OP_MUL, R21, R20, R15);     n++;
    p[n] = mk(OP_ZIFZ, R21, R21, R19);    n++;
    p[n] = mk(OP_GSEL, R21, R21, S_ZERO); n++;
    p[n] = mk(OP_MUL, R22, R20, R16);     n++;
    p[n] = mk(OP_ZIFZ, R22, R22, R19);    n++;
    p[n] = mk(OP_GSEL, R22, R22, S_ZERO); n++;
    p[n] = mk(OP_MUL, R23, R20, R17);     n++;
    p[n] = mk(OP_ZIFZ, R23, R23, R19);    n++;
    p[n] = mk(OP_GSEL, R23, R23, S_ZERO); n++;
    p[n] = mk(OP_MUL, R24, R20, R18);     n++;
    p[n] = mk(OP_ZIFZ, R24, R24, R19);    n++;
    p[n] = mk(OP_GSEL, R24, R24, S_ZERO); n++;
    // integrate into R25..R28
    p[n] = mk(OP_SUB, R4, R6, R21);    n++;
    p[n] = mk(OP_MUL, R4, R4, S_DT);   n++;
    p[n] = mk(OP_ADD, R25, S_PW, R4);  n++;
    p[n] = mk(OP_SUB, R4, R7, R22);    n++;
    p[n] = mk(OP_MUL, R4, R4, S_DT);   n++;
    p[n] = mk(OP_ADD, R26, S_PX, R4);  n++;
    p[n] = mk(OP_SUB, R4, R8, R23);    n++;
    p[n] = mk(OP_MUL, R4, R4, S_DT);   n++;
    p[n] = mk(OP_ADD, R27, S_PY, R4);  n++;
    p[n] = mk(OP_SUB, R4, R9, R24);    n++;
    p[n] = mk(OP_MUL, R4, R4, S_DT);   n++;
    p[n] = mk(OP_ADD, R28, S_PZ, R4);  n++;
    // renormalize; a zero norm multiplies by one
    p[n] = mk(OP_MUL, R4, R25, R25); n++;
    p[n] = mk(OP_MUL, R5, R26, R26); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);   n++;
    p[n] = mk(OP_MUL, R5, R27, R27); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);   n++;
    p[n] = mk(OP_MUL, R5, R28, R28); n++;
    p[n] = mk(OP_ADD, R29, R4, R5);  n++;
    p[n] = mk(OP_ISQ, R30, R29, S_ZERO); n++;
    p[n] = mk(OP_ONEIFZ, R30, R30, R29); n++;
    p[n] = mk(OP_MUL, R25, R25, R30); n++;
    p[n] = mk(OP_MUL, R26, R26, R30); n++;
    p[n] = mk(OP_MUL, R27, R27, R30); n++;
    p[n] = mk(OP_MUL, R28, R28, R30); n++;
    // hemisphere test against previous orientation
    p[n] = mk(OP_MUL, R4, R25, S_PW); n++;
    p[n] = mk(OP_MUL, R5, R26, S_PX); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R27, S_PY); n++;
    p[n] = mk(OP_ADD, R4, R4, R5);    n++;
    p[n] = mk(OP_MUL, R5, R28, S_PZ); n++;
    p[n] = mk(OP_ADD, R29, R4, R5);   n++;
    p[n] = mk(OP_NEGIFN, R25, R25, R29); n++;
    p[n] = mk(OP_NEGIFN, R26, R26, R29); n++;
    p[n] = mk(OP_NEGIFN, R27, R27, R29); n++;
    p[n] = mk(OP_NEGIFN, R28, R28, R29); n++;
    // commit
    p[n] = mk(OP_STO, O_W, R25, S_ZERO); n++;
    p[n] = mk(OP_STO, O_X, R26, S_ZERO); n++;
    p[n] = mk(OP_STO, O_Y, R27, S_ZERO); n++;
    p[n] = mk(OP_STO, O_Z, R28, S_ZERO); n++;
    p[n] = mk(OP_END, R0, S_ZERO, S_ZERO);
    return p[pc];
  endfunction

endpackage

FILE: sv/imu_orientation_fusion_step.sv
// Top level of the gyro/accelerometer orientation filter: sequencer, item and
// configuration ports, orientation state. Uses ofs_pkg, ofs_regfile, ofs_alu, ofs_isqrt.
//
// Each item (gyro rate, specific force, time step) updates the stored Q16.16
// orientation quaternion, which resets to identity, and yields one result: the
// new quaternion and a flag telling whether the acceleration passed the norm gate.
// The update runs as a microprogram of about 180 instructions on one shared
// saturating multiply/add unit, each instruction passing a register file read
// state and then an execute state, plus three passes through a bit-serial inverse
// square root. The input is not ready while an item is in work; a finished result
// waits in the output register while the next item is taken. Configuration
// writes are always ready; indexes past the gate registers are ignored.
module imu_orientation_fusion_step (
  input  logic          clk,
  input  logic          rst,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, time_step (lowest bits first)
  input  logic [207:0]  s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z (lowest bits first)
  output logic [127:0]  m_axis_tdata,
  // accel_used
  output logic [0:0]    m_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import ofs_pkg::*;

  seq_state_t state, state_next;
  logic [7:0] pc;
  instr_t     ir;
  instr_t     fetched;

  // configuration
  logic [30:0] beta_gain, gate_low, gate_high;

  // item fields and orientation
  logic signed [31:0] rx, ry, rz, ax, ay, az;
  logic [15:0]        dt;
  logic signed [31:0] orient_w, orient_x, orient_y, orient_z;
  logic               used;

  // operands
  logic               a_spec, b_spec;
  logic signed [31:0] spec_a, spec_b;
  logic [31:0]        rf_a, rf_b;
  logic signed [31:0] opa, opb;
  logic signed [31:0] alu_res;
  logic               gate_pass;

  // register file write
  logic               rf_we;
  logic [31:0]        rf_wdata;

  isq_req_t isq_req;
  isq_rsp_t isq_rsp;
  logic     out_load;
  logic     exec_write;

  function automatic logic signed [31:0] spec_val(input logic [5:0] code,
      input logic signed [31:0] vrx, input logic signed [31:0] vry,
      input logic signed [31:0] vrz, input logic signed [31:0] vax,
      input logic signed [31:0] vay, input logic signed [31:0] vaz,
      input logic [15:0] vdt, input logic [30:0] vbeta,
      input logic signed [31:0] pw, input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz);
    logic signed [31:0] v;
    unique case (code)
      S_RX:    v = vrx;
      S_RY:    v = vry;
      S_RZ:    v = vrz;
      S_AX:    v = vax;
      S_AY:    v = vay;
      S_AZ:    v = vaz;
      S_DT:    v = {16'd0, vdt};
      S_BETA:  v = {1'b0, vbeta};
      S_ONE:   v = Q_ONE;
      S_PW:    v = pw;
      S_PX:    v = px;
      S_PY:    v = py;
      S_PZ:    v = pz;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign fetched = prog_at(pc);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      beta_gain <= BETA_RST;
      gate_low  <= GATE_LO_RST;
      gate_high <= GATE_HI_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BETA:    beta_gain <= cfg_data[30:0];
        CFG_GATE_LO: gate_low  <= cfg_data[30:0];
        CFG_GATE_HI: gate_high <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE:  if (s_axis_tvalid) state_next = SQ_FETCH;
      SQ_FETCH: state_next = SQ_EXEC;
      SQ_EXEC: begin
        if (ir.op == OP_ISQ) state_next = SQ_ISQ;
        else if (ir.op == OP_END) state_next = SQ_DONE;
        else state_next = SQ_FETCH;
      end
      SQ_ISQ:   if (isq_rsp.done) state_next = SQ_FETCH;
      SQ_DONE:  if (!m_axis_tvalid || m_axis_tready) state_next = SQ_IDLE;
      default:  state_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = (state == SQ_IDLE);
    out_load      = (state == SQ_DONE) && (!m_axis_tvalid || m_axis_tready);
    isq_req.start = (state == SQ_EXEC) && (ir.op == OP_ISQ);
    isq_req.x     = opa;
    exec_write    = (state == SQ_EXEC) && (ir.op != OP_ISQ) && (ir.op != OP_GATE)
                    && (ir.op != OP_STO) && (ir.op != OP_END);
    rf_we         = exec_write || ((state == SQ_ISQ) && isq_rsp.done);
    rf_wdata      = (state == SQ_ISQ) ? isq_rsp.result : alu_res;
  end

  // program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      pc <= '0;
    end else if ((state == SQ_EXEC && ir.op != OP_ISQ && ir.op != OP_END)
                 || (state == SQ_ISQ && isq_rsp.done)) begin
      pc <= pc + 8'd1;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rx <= s_axis_tdata[31:0];
      ry <= s_axis_tdata[63:32];
      rz <= s_axis_tdata[95:64];
      ax <= s_axis_tdata[127:96];
      ay <= s_axis_tdata[159:128];
      az <= s_axis_tdata[191:160];
      dt <= s_axis_tdata[207:192];
    end
  end

  // instruction and special operand registers
  always_ff @(posedge clk) begin
    if (state == SQ_FETCH) begin
      ir     <= fetched;
      a_spec <= fetched.a[5];
      b_spec <= fetched.b[5];
      spec_a <= spec_val(fetched.a, rx, ry, rz, ax, ay, az, dt, beta_gain,
                         orient_w, orient_x, orient_y, orient_z);
      spec_b <= spec_val(fetched.b, rx, ry, rz, ax, ay, az, dt, beta_gain,
                         orient_w, orient_x, orient_y, orient_z);
    end
  end

  assign opa = a_spec ? spec_a : rf_a;
  assign opb = b_spec ? spec_b : rf_b;

  // accel norm gate
  assign gate_pass = ($signed({2'b00, gate_low}) <= $signed({opa[31], opa}))
                  && ($signed({opa[31], opa}) <= $signed({2'b00, gate_high}));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (state == SQ_EXEC && ir.op == OP_GATE) begin
      used <= gate_pass;
    end
  end

  // orientation state
  always_ff @(posedge clk) begin
    if (rst) begin
      orient_w <= Q_ONE;
      orient_x <= '0;
      orient_y <= '0;
      orient_z <= '0;
    end else if (state == SQ_EXEC && ir.op == OP_STO) begin
      case (ir.d)
        O_W:     orient_w <= opa;
        O_X:     orient_x <= opa;
        O_Y:     orient_y <= opa;
        default: orient_z <= opa;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {orient_z, orient_y, orient_x, orient_w};
      m_axis_tuser <= used;
    end
  end

  ofs_regfile u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (ir.d[4:0]),
    .wdata   (rf_wdata),
    .raddr_a (fetched.a[4:0]),
    .raddr_b (fetched.b[4:0]),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  ofs_alu u_alu (
    .op      (ir.op),
    .a       (opa),
    .b       (opb),
    .gate_ok (used),
    .res     (alu_res)
  );

  ofs_isqrt u_isq (
    .clk (clk),
    .rst (rst),
    .req (isq_req),
    .rsp (isq_rsp)
  );

  // inverse root runs only while the sequencer waits on it
  a_isq_wait: assert property (@(posedge clk) disable iff (rst)
    (isq_rsp.busy && !isq_rsp.done) |-> (state == SQ_ISQ))
    else $error("inverse root busy outside its wait state");

  // orientation w and z components change only by a store instruction
  a_orient_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == SQ_EXEC && ir.op == OP_STO) |=> $stable(orient_w) && $stable(orient_z))
    else $error("orientation changed without a store");

  // a loaded result is presented next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid && (state == SQ_IDLE))
    else $error("result load lost");

endmodule

FILE: sv/ofs_regfile.sv
// Scratch register file of the orientation filter: 32 x 32 bits,
// one write port, two registered read ports. Depends on nothing.
module ofs_regfile (
  input  logic        clk,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [4:0]  raddr_a,
  input  logic [4:0]  raddr_b,
  output logic [31:0] rdata_a,
  output logic [31:0] rdata_b
);

  logic [31:0] mem [32];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/ofs_alu.sv
// Shared saturating Q16.16 arithmetic unit: multiply, add, subtract, negate, halve and selects.
// Depends on ofs_pkg.
module ofs_alu (
  input  ofs_pkg::op_t        op,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  input  logic                gate_ok,
  output logic signed [31:0]  res
);
  import ofs_pkg::*;

  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic signed [32:0] sum;
  logic signed [32:0] dif;
  logic signed [31:0] mul_s;
  logic signed [31:0] add_s;
  logic signed [31:0] sub_s;
  logic signed [31:0] neg_a;

  // multiply with floor shift and saturation
  assign prod    = 64'(a) * 64'(b);
  assign prod_sh = prod >>> 16;
  always_comb begin
    if (prod_sh > 64'sh0000_0000_7FFF_FFFF) mul_s = Q_MAX;
    else if (prod_sh < -64'sh0000_0000_8000_0000) mul_s = Q_MIN;
    else mul_s = prod_sh[31:0];
  end

  // saturating add and subtract
  assign sum = 33'(a) + 33'(b);
  assign dif = 33'(a) - 33'(b);
  assign add_s = (sum[32] != sum[31]) ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
  assign sub_s = (dif[32] != dif[31]) ? (dif[32] ? Q_MIN : Q_MAX) : dif[31:0];
  assign neg_a = (a == Q_MIN) ? Q_MAX : -a;

  // result select
  always_comb begin
    unique case (op)
      OP_MUL:    res = mul_s;
      OP_ADD:    res = add_s;
      OP_SUB:    res = sub_s;
      OP_NEG:    res = neg_a;
      OP_HALF:   res = a >>> 1;
      OP_GSEL:   res = gate_ok ? a : '0;
      OP_ZIFZ:   res = (b == '0) ? '0 : a;
      OP_ONEIFZ: res = (b == '0) ? Q_ONE : a;
      OP_NEGIFN: res = b[31] ? neg_a : a;
      default:   res = a;
    endcase
  end

endmodule

FILE: sv/ofs_isqrt.sv
// Iterative inverse square root: floor(sqrt(floor(2^48 / x))), one bit per cycle
// (49 division steps then 25 root steps). Depends on ofs_pkg.
module ofs_isqrt (
  input  logic              clk,
  input  logic              rst,
  input  ofs_pkg::isq_req_t req,
  output ofs_pkg::isq_rsp_t rsp
);
  import ofs_pkg::*;

  isq_state_t  state, state_next;
  logic [30:0] divisor;
  logic [31:0] rem;
  logic [49:0] quo;
  logic [27:0] rrem;
  logic [24:0] root;
  logic [5:0]  cnt;
  logic        nonpos;

  logic [31:0] dsh;
  logic        dge;
  logic [27:0] rsh;
  logic [27:0] trial;
  logic        rge;

  // one restoring division step; the dividend is a single one at bit 48
  assign dsh = {rem[30:0], (cnt == '0)};
  assign dge = dsh >= {1'b0, divisor};

  // one digit-by-digit root step
  assign rsh   = {rrem[25:0], quo[49:48]};
  assign trial = {1'b0, root, 2'b01};
  assign rge   = rsh >= trial;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ISQ_IDLE: if (req.start) state_next = (req.x <= 0) ? ISQ_DONE : ISQ_DIV;
      ISQ_DIV:  if (cnt == 6'd48) state_next = ISQ_ROOT;
      ISQ_ROOT: if (cnt == 6'd24) state_next = ISQ_DONE;
      ISQ_DONE: state_next = ISQ_IDLE;
      default:  state_next = ISQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ISQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ISQ_IDLE: begin
        divisor <= req.x[30:0];
        nonpos  <= (req.x <= 0);
        rem     <= '0;
        quo     <= '0;
        rrem    <= '0;
        root    <= '0;
        cnt     <= '0;
      end
      ISQ_DIV: begin
        rem <= dge ? dsh - {1'b0, divisor} : dsh;
        quo <= {quo[48:0], dge};
        cnt <= (cnt == 6'd48) ? '0 : cnt + 6'd1;
      end
      ISQ_ROOT: begin
        rrem <= rge ? rsh - trial : rsh;
        root <= {root[23:0], rge};
        quo  <= {quo[47:0], 2'b00};
        cnt  <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    rsp.busy   = (state != ISQ_IDLE);
    rsp.done   = (state == ISQ_DONE);
    rsp.result = nonpos ? Q_MAX : {7'd0, root};
  end

endmodule

FILE: sim/tb.sv
// Self-checking bench for imu_orientation_fusion_step: a Q16.16 predictor of the
// filter update checks every result. Depends on ofs_pkg and the block's RTL.
module tb;
  import ofs_pkg::*;

  typedef logic signed [31:0] q_t;
  typedef struct {
    q_t w, x, y, z;
  } quat_t;
  typedef struct {
    quat_t      q;
    logic       used;
  } orient_res_t;

  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index past the register list
  localparam int LIMIT = 6000000;
  localparam int DRAIN = 800;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [207:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // predictor state
  quat_t       orient;
  logic [30:0] beta_m, gate_lo_m, gate_hi_m;
  orient_res_t expected_q[$];
  int          err_cnt = 0;
  int          cycles = 0;
  bit          no_idle = 0;

  imu_orientation_fusion_step u_dut (.*);

  always #5 clk = ~clk;

  // ---------------- Q16.16 arithmetic ----------------
  function automatic q_t sat(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return q_t'(v);
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat(p >>> 16);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat(longint'(a) + longint'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat(longint'(a) - longint'(b));
  endfunction

  function automatic q_t qneg(input q_t a);
    return sat(-longint'(a));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic q_t inv_root(input q_t x);
    longint unsigned u;
    if (x <= 0) return Q_MAX;
    u = longint'(x);
    return sat(longint'(int_sqrt((64'd1 << 48) / u)));
  endfunction

  function automatic quat_t hprod(input quat_t a, input quat_t b);
    quat_t r;
    r.w = qsub(qsub(qsub(qmul(a.w, b.w), qmul(a.x, b.x)), qmul(a.y, b.y)), qmul(a.z, b.z));
    r.x = qsub(qadd(qadd(qmul(a.w, b.x), qmul(a.x, b.w)), qmul(a.y, b.z)), qmul(a.z, b.y));
    r.y = qadd(qadd(qsub(qmul(a.w, b.y), qmul(a.x, b.z)), qmul(a.y, b.w)), qmul(a.z, b.x));
    r.z = qadd(qsub(qadd(qmul(a.w, b.z), qmul(a.x, b.y)), qmul(a.y, b.x)), qmul(a.z, b.w));
    return r;
  endfunction

  // gradient step toward gravity; returns gate flag
  function automatic logic grad_step(input quat_t q, input q_t ax, input q_t ay, input q_t az,
                                     output quat_t s);
    q_t    n2, inv, fx, fy, fz, gw, gx, gy, gz, g2, scale;
    quat_t gb, grav, qc;
    s = '{0, 0, 0, 0};
    grav = '{0, 0, 0, Q_ONE};
    n2 = qadd(qadd(qmul(ax, ax), qmul(ay, ay)), qmul(az, az));
    if (longint'(gate_lo_m) > longint'(n2) || longint'(n2) > longint'(gate_hi_m)) return 1'b0;
    inv = inv_root(n2);
    ax = qneg(qmul(inv, ax));
    ay = qneg(qmul(inv, ay));
    az = qneg(qmul(inv, az));
    qc = '{q.w, qneg(q.x), qneg(q.y), qneg(q.z)};
    gb = hprod(hprod(qc, grav), q);
    fx = qsub(gb.x, ax);
    fy = qsub(gb.y, ay);
    fz = qsub(gb.z, az);
    gw = qadd(qsub(qmul(q.x, fy), qmul(q.y, fx)), qsub(qmul(q.x, fy), qmul(q.y, fx)));
    gx = qsub(qadd(qmul(q.z, fx), qmul(q.w, fy)), qadd(qmul(q.x, fz), qmul(q.x, fz)));
    gx = qadd(gx, gx);
    gy = qsub(qmul(q.z, fy), qadd(qmul(q.w, fx), qadd(qmul(q.y, fz), qmul(q.y, fz))));
    gy = qadd(gy, gy);
    gz = qadd(qmul(q.x, fx), qmul(q.y, fy));
    gz = qadd(gz, gz);
    g2 = qadd(qadd(qmul(gw, gw), qmul(gx, gx)), qadd(qmul(gy, gy), qmul(gz, gz)));
    if (g2 == 0) return 1'b1;
    scale = qmul(q_t'({1'b0, beta_m}), inv_root(g2));
    s = '{qmul(scale, gw), qmul(scale, gx), qmul(scale, gy), qmul(scale, gz)};
    return 1'b1;
  endfunction

  // one filter update on the model state
  function automatic orient_res_t fuse_update(input logic [207:0] d);
    quat_t       prev, half, rate, dq, s, q;
    q_t          dt, n2, inv, hd;
    orient_res_t r;
    prev = orient;
    half = '{prev.w >>> 1, prev.x >>> 1, prev.y >>> 1, prev.z >>> 1};
    rate = '{0, q_t'(d[31:0]), q_t'(d[63:32]), q_t'(d[95:64])};
    dq = hprod(half, rate);
    r.used = grad_step(prev, q_t'(d[127:96]), q_t'(d[159:128]), q_t'(d[191:160]), s);
    dt = q_t'({16'd0, d[207:192]});
    q.w = qadd(prev.w, qmul(qsub(dq.w, s.w), dt));
    q.x = qadd(prev.x, qmul(qsub(dq.x, s.x), dt));
    q.y = qadd(prev.y, qmul(qsub(dq.y, s.y), dt));
    q.z = qadd(prev.z, qmul(qsub(dq.z, s.z), dt));
    n2 = qadd(qadd(qadd(qmul(q.w, q.w), qmul(q.x, q.x)), qmul(q.y, q.y)), qmul(q.z, q.z));
    if (n2 != 0) begin
      inv = inv_root(n2);
      q = '{qmul(q.w, inv), qmul(q.x, inv), qmul(q.y, inv), qmul(q.z, inv)};
    end
    hd = qadd(qadd(qadd(qmul(q.w, prev.w), qmul(q.x, prev.x)), qmul(q.y, prev.y)),
              qmul(q.z, prev.z));
    if (hd < 0) q = '{qneg(q.w), qneg(q.x), qneg(q.y), qneg(q.z)};
    orient = q;
    r.q = q;
    return r;
  endfunction

  // ---------------- drivers ----------------
  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_item(input q_t rx, input q_t ry, input q_t rz, input q_t ax,
                           input q_t ay, input q_t az, input logic [15:0] dt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, az, ay, ax, rz, ry, rx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(fuse_update({dt, az, ay, ax, rz, ry, rx}));
  endtask

  // stop sending and let every pending result arrive
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BETA:    beta_m    = val[30:0];
      CFG_GATE_LO: gate_lo_m = val[30:0];
      CFG_GATE_HI: gate_hi_m = val[30:0];
      default: ;
    endcase
  endtask

  // random item: mostly plausible motion, some raw noise on every bit
  task automatic send_random();
    q_t rx, ry, rz, ax, ay, az;
    logic [15:0] dt;
    if ($urandom_range(0, 9) < 8) begin
      rx = $signed($urandom_range(0, 600000)) - 300000;
      ry = $signed($urandom_range(0, 600000)) - 300000;
      rz = $signed($urandom_range(0, 600000)) - 300000;
      ax = $signed($urandom_range(0, 160000)) - 80000;
      ay = $signed($urandom_range(0, 160000)) - 80000;
      az = $signed($urandom_range(0, 160000)) - 80000;
      dt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    end else begin
      rx = $urandom; ry = $urandom; rz = $urandom;
      ax = $urandom; ay = $urandom; az = $urandom;
      dt = $urandom;
    end
    send_item(rx, ry, rz, ax, ay, az, dt);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    orient_res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", m_axis_tdata);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== e.q.w) begin
          $error("quat_w exp %h got %h", e.q.w, m_axis_tdata[31:0]); err_cnt++;
        end
        if (m_axis_tdata[63:32] !== e.q.x) begin
          $error("quat_x exp %h got %h", e.q.x, m_axis_tdata[63:32]); err_cnt++;
        end
        if (m_axis_tdata[95:64] !== e.q.y) begin
          $error("quat_y exp %h got %h", e.q.y, m_axis_tdata[95:64]); err_cnt++;
        end
        if (m_axis_tdata[127:96] !== e.q.z) begin
          $error("quat_z exp %h got %h", e.q.z, m_axis_tdata[127:96]); err_cnt++;
        end
        if (m_axis_tuser[0] !== e.used) begin
          $error("accel_used exp %b got %b", e.used, m_axis_tuser[0]); err_cnt++;
        end
      end
    end
  end

  // result side back-pressure, one draw per item
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    q_t g;
    g = Q_ONE;
    send_item(0, 0, 0, 0, 0, -g, 16'd65);          // level, zero gradient
    send_item(0, 0, 0, 0, 0, g, 16'd65);
    send_item(g, -g, g >>> 1, g >>> 2, 0, -g, 16'd655);
    send_item(Q_MAX, Q_MAX, Q_MAX, 0, 0, -g, 16'hFFFF);
    send_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'hFFFF);
    send_item(Q_MAX, 0, 0, Q_MAX, Q_MAX, Q_MAX, 16'h0000);
    send_item(0, 0, 0, 3 * g, 0, 0, 16'd100);      // gate rejects high
    send_item(0, 0, 0, g >>> 3, 0, 0, 16'd100);    // gate rejects low
    send_item(0, 0, 0, 0, 0, 0, 16'd100);
    send_item(32'sd400000, 0, 0, 0, g, 0, 16'd60000); // large turn, hemisphere flip
    send_item(0, 32'sd400000, 0, 0, 0, -g, 16'd60000);
    send_item(0, 0, 32'sd400000, g, 0, 0, 16'd60000);
    send_item(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'd1);
  endtask

  task automatic test_gate_extremes();
    write_reg(CFG_GATE_LO, 32'd0);
    write_reg(CFG_GATE_HI, 32'hFFFF_FFFF);   // upper bit masked off
    send_item(0, 0, 0, 0, 0, 0, 16'd500);    // zero norm passes, inverse root saturates
    send_item(Q_ONE, 0, 0, Q_MAX, Q_MIN, Q_MAX, 16'd500);
    write_reg(CFG_BETA, 32'h7FFF_FFFF);
    send_item(0, 0, 0, Q_ONE, Q_ONE, 0, 16'd2000);
    send_item(0, 0, 0, 0, Q_ONE, 0, 16'hFFFF);
    write_reg(CFG_BETA, 32'd0);
    send_item(0, 0, 0, Q_ONE, 0, 0, 16'd2000);
    write_reg(CFG_GATE_LO, 32'h7FFF_FFFF);
    write_reg(CFG_GATE_HI, 32'd0);           // empty window
    send_item(0, 0, 0, 0, 0, -Q_ONE, 16'd2000);
  endtask

  task automatic test_unused_index();
    write_reg(CFG_UNUSED, 32'h1234_5678);
    send_item(Q_ONE, 0, 0, 0, 0, -Q_ONE, 16'd300);
  endtask

  task automatic test_random(input logic [31:0] beta, input logic [31:0] lo,
                             input logic [31:0] hi, input int n);
    write_reg(CFG_BETA, beta);
    write_reg(CFG_GATE_LO, lo);
    write_reg(CFG_GATE_HI, hi);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_random();
    end
    no_idle = 0;
  endtask

  initial begin
    orient    = '{Q_ONE, 0, 0, 0};
    beta_m    = BETA_RST;
    gate_lo_m = GATE_LO_RST;
    gate_hi_m = GATE_HI_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_gate_extremes();
    test_unused_index();
    test_random(32'd6554, 32'd53084, 32'd79299, 500);
    test_random(32'd40000, 32'd0, 32'd200000, 500);
    test_random(32'd600, 32'd20000, 32'h7FFF_FFFF, 500);
    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
